// ===== rtl/fdmd_pkg.sv =====
package fdmd_pkg;

  localparam int FRAME_WIDTH_W = 13;
  localparam int STRIDE_W      = 5;
  localparam int THRESH_W      = 8;
  localparam int LIMIT_W       = 20;
  localparam int COUNT_W       = 21;
  localparam int CHAN_W        = 8;
  localparam int GRAY_W        = 8;
  localparam int CFG_DATA_W    = 20;
  localparam int CFG_INDEX_W   = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_STRIDE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT    = 2'd3;

  localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET    = 13'd640;
  localparam logic [STRIDE_W-1:0]      SAMPLE_STRIDE_RESET  = 5'd4;
  localparam logic [THRESH_W-1:0]      DIFF_THRESHOLD_RESET = 8'd30;
  localparam logic [LIMIT_W-1:0]       COUNT_LIMIT_RESET    = 20'd2500;

  typedef struct packed {
    logic [CHAN_W-1:0] ref_red;
    logic [CHAN_W-1:0] ref_green;
    logic [CHAN_W-1:0] ref_blue;
    logic [CHAN_W-1:0] cur_red;
    logic [CHAN_W-1:0] cur_green;
    logic [CHAN_W-1:0] cur_blue;
    logic              frame_end;
  } pixel_pair_t;

  typedef struct packed {
    logic               change_detected;
    logic [COUNT_W-1:0] changed_count;
  } motion_result_t;

endpackage

// ===== rtl/frame_difference_motion_detector.sv =====
// Frame-difference motion detector.
// The pix channel carries one reference/current RGB pixel pair per item in
// raster order; frame_end marks the last pixel of a frame. For that pixel only,
// one item leaves on res with the change flag and the number of sampled pixels
// whose gray difference exceeded the threshold, counted until the flag sets.
// Configuration (frame width, sample stride, threshold, count limit) is written
// through cfg_write/cfg_index/cfg_data and takes effect on the next pixel.
// Pipeline: an input register holds the two gray values of the accepted pixel;
// when that pixel is processed, the raster counters and the change count are
// updated and the result register is loaded. One pixel is accepted in every
// cycle unless a frame_end pixel is held back as described below.
// When the receiver stalls, pixels keep flowing; only a frame_end pixel waits
// in the input register while an earlier result has not yet been taken, and
// then pix_ready drops until the result register frees up.
// Reset restores the register defaults (640, 4, 30, 2500), clears the raster
// position and the count, and empties both pipeline registers. No clearing
// pass is needed.
module frame_difference_motion_detector
  import fdmd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_STRIDE = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  pixel_pair_t            pix,
  output logic                   res_valid,
  input  logic                   res_ready,
  output motion_result_t         res,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WCMP_W   = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
  localparam int PH_W     = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int SCMP_W   = (PH_W + 1 > STRIDE_W) ? PH_W + 1 : STRIDE_W;
  localparam int GSUM_W   = GRAY_W + 5;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
    logic [GSUM_W-1:0] sum;
    sum = GSUM_W'(r) * GSUM_W'(11) + GSUM_W'(g) * GSUM_W'(16) + GSUM_W'(b) * GSUM_W'(5);
    return sum[GSUM_W-1:5];
  endfunction

  // Configuration registers.
  logic [FRAME_WIDTH_W-1:0] frame_width;
  logic [STRIDE_W-1:0]      sample_stride;
  logic [THRESH_W-1:0]      diff_threshold;
  logic [LIMIT_W-1:0]       count_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RESET;
      sample_stride  <= SAMPLE_STRIDE_RESET;
      diff_threshold <= DIFF_THRESHOLD_RESET;
      count_limit    <= COUNT_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_SAMPLE_STRIDE:  sample_stride  <= cfg_data[STRIDE_W-1:0];
        REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[THRESH_W-1:0];
        REG_COUNT_LIMIT:    count_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: gray values of both pixels plus the frame marker.
  logic              s1_valid;
  logic [GRAY_W-1:0] s1_gray_ref;
  logic [GRAY_W-1:0] s1_gray_cur;
  logic              s1_frame_end;
  logic              process;

  // A pixel that produces no result never waits for the result register.
  assign process   = s1_valid && (!s1_frame_end || !res_valid || res_ready);
  assign pix_ready = !s1_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      s1_gray_ref  <= gray_of(pix.ref_red, pix.ref_green, pix.ref_blue);
      s1_gray_cur  <= gray_of(pix.cur_red, pix.cur_green, pix.cur_blue);
      s1_frame_end <= pix.frame_end;
    end
  end

  // Raster and count state.
  logic [COL_W-1:0]   column_pos, column_pos_next;
  logic [PH_W-1:0]    x_phase, x_phase_next;
  logic [PH_W-1:0]    y_phase, y_phase_next;
  logic [COUNT_W-1:0] changed_points, changed_points_next;
  logic               detected, detected_next;

  logic [WCMP_W-1:0]  width_eff;
  logic [SCMP_W-1:0]  stride_eff;
  logic [GRAY_W-1:0]  diff;
  logic               sampled;
  logic               line_wrap;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = WCMP_W'(1);
    end else if (WCMP_W'(frame_width) > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      width_eff = WCMP_W'(frame_width);
    end

    if (sample_stride == '0) begin
      stride_eff = SCMP_W'(1);
    end else if (SCMP_W'(sample_stride) > SCMP_W'(MAX_STRIDE)) begin
      stride_eff = SCMP_W'(MAX_STRIDE);
    end else begin
      stride_eff = SCMP_W'(sample_stride);
    end

    diff = (s1_gray_ref > s1_gray_cur) ? s1_gray_ref - s1_gray_cur
                                       : s1_gray_cur - s1_gray_ref;
    sampled   = (x_phase == '0) && (y_phase == '0) && !detected;
    count_inc = changed_points + COUNT_W'(1);

    changed_points_next = changed_points;
    detected_next       = detected;
    if (sampled && (diff > diff_threshold)) begin
      changed_points_next = count_inc;
      detected_next       = count_inc > COUNT_W'(count_limit);
    end

    line_wrap = (WCMP_W'(column_pos) + WCMP_W'(1)) >= width_eff;
    if (line_wrap) begin
      column_pos_next = '0;
      x_phase_next    = '0;
      y_phase_next    = ((SCMP_W'(y_phase) + SCMP_W'(1)) >= stride_eff) ? '0
                                                                         : y_phase + PH_W'(1);
    end else begin
      column_pos_next = column_pos + COL_W'(1);
      x_phase_next    = ((SCMP_W'(x_phase) + SCMP_W'(1)) >= stride_eff) ? '0
                                                                         : x_phase + PH_W'(1);
      y_phase_next    = y_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos     <= '0;
      x_phase        <= '0;
      y_phase        <= '0;
      changed_points <= '0;
      detected       <= 1'b0;
    end else if (process) begin
      if (s1_frame_end) begin
        column_pos     <= '0;
        x_phase        <= '0;
        y_phase        <= '0;
        changed_points <= '0;
        detected       <= 1'b0;
      end else begin
        column_pos     <= column_pos_next;
        x_phase        <= x_phase_next;
        y_phase        <= y_phase_next;
        changed_points <= changed_points_next;
        detected       <= detected_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (process && s1_frame_end) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && s1_frame_end) begin
      res.change_detected <= detected_next;
      res.changed_count   <= changed_points_next;
    end
  end

  // The flag is only ever set by a count above the limit, so it never goes
  // with an empty count.
  assert property (@(posedge clk) disable iff (rst)
    detected |-> changed_points != '0)
    else $error("change flag set with zero count");

  // Input back-pressure only comes from a frame-end item behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> s1_valid && s1_frame_end && res_valid && !res_ready)
    else $error("pixel stalled without a held result");

  // A frame-end item leaves the frame state cleared.
  assert property (@(posedge clk) disable iff (rst)
    process && s1_frame_end |=> column_pos == '0 && x_phase == '0 && y_phase == '0
                                && changed_points == '0 && !detected)
    else $error("frame state not cleared after frame end");

  // A waiting item in the input register is neither lost nor altered.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !process |=> s1_valid && $stable(s1_gray_ref) && $stable(s1_gray_cur)
                             && $stable(s1_frame_end))
    else $error("input register changed while stalled");

  // A new result is loaded only once the previous one is gone or taken.
  assert property (@(posedge clk) disable iff (rst)
    process && s1_frame_end |-> !res_valid || res_ready)
    else $error("result overwritten before it was taken");

endmodule

// ===== test/tb_frame_difference_motion_detector.sv =====
`timescale 1ns / 100ps

module tb_frame_difference_motion_detector;
  import fdmd_pkg::*;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_STRIDE   = 16;
  localparam int PIPE_SETTLE  = 4;
  localparam int RANDOM_ITEMS = 700;
  localparam int MIN_FRAMES   = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   pix_valid = 1'b0;
  logic                   pix_ready;
  pixel_pair_t            pix = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  motion_result_t         res;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_difference_motion_detector #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_STRIDE(MAX_STRIDE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Register copies and raster state of the detector as the testbench sees it.
  logic [FRAME_WIDTH_W-1:0] width_reg;
  logic [STRIDE_W-1:0]      stride_reg;
  logic [THRESH_W-1:0]      threshold_reg;
  logic [LIMIT_W-1:0]       limit_reg;
  int                       column_at;
  int                       x_phase_at;
  int                       y_phase_at;
  int                       changed_samples;
  bit                       motion_seen;

  motion_result_t pending_results[$];
  motion_result_t oldest_result;
  int             mismatch_count = 0;
  bit             gaps_enabled = 1'b1;
  int             ready_stall = 0;

  function automatic int gray_level(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return (11 * int'(r) + 16 * int'(g) + 5 * int'(b)) >> 5;
  endfunction

  function automatic void clear_frame();
    column_at       = 0;
    x_phase_at      = 0;
    y_phase_at      = 0;
    changed_samples = 0;
    motion_seen     = 1'b0;
  endfunction

  function automatic void account_pixel(pixel_pair_t p);
    int stride;
    int width;
    int diff;
    stride = int'(stride_reg);
    width  = int'(width_reg);
    if (stride == 0) stride = 1;
    else if (stride > MAX_STRIDE) stride = MAX_STRIDE;
    if (width == 0) width = 1;
    else if (width > MAX_WIDTH) width = MAX_WIDTH;

    if (x_phase_at == 0 && y_phase_at == 0 && !motion_seen) begin
      diff = gray_level(p.ref_red, p.ref_green, p.ref_blue)
           - gray_level(p.cur_red, p.cur_green, p.cur_blue);
      if (diff < 0) diff = -diff;
      if (diff > int'(threshold_reg)) begin
        changed_samples++;
        if (changed_samples > int'(limit_reg)) motion_seen = 1'b1;
      end
    end

    // A counter left beyond a freshly lowered bound wraps on its next advance.
    if (column_at + 1 >= width) begin
      column_at  = 0;
      x_phase_at = 0;
      y_phase_at = (y_phase_at + 1 >= stride) ? 0 : y_phase_at + 1;
    end else begin
      column_at++;
      x_phase_at = (x_phase_at + 1 >= stride) ? 0 : x_phase_at + 1;
    end

    if (p.frame_end) begin
      pending_results.push_back(motion_result_t'{change_detected: motion_seen,
                                                 changed_count: COUNT_W'(changed_samples)});
      clear_frame();
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_pair_t gray_pair(int ref_level, int cur_level, bit last);
    pixel_pair_t p;
    p.ref_red   = 8'(ref_level);
    p.ref_green = 8'(ref_level);
    p.ref_blue  = 8'(ref_level);
    p.cur_red   = 8'(cur_level);
    p.cur_green = 8'(cur_level);
    p.cur_blue  = 8'(cur_level);
    p.frame_end = last;
    return p;
  endfunction

  function automatic pixel_pair_t random_pixel(bit last);
    pixel_pair_t p;
    int          roll;
    int          level;
    int          other;
    int          delta;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      p.ref_red   = 8'($urandom);
      p.ref_green = 8'($urandom);
      p.ref_blue  = 8'($urandom);
      p.cur_red   = 8'($urandom);
      p.cur_green = 8'($urandom);
      p.cur_blue  = 8'($urandom);
      p.frame_end = last;
    end else if (roll < 75) begin
      // Gray difference just around the threshold.
      level = $urandom_range(0, 255);
      delta = int'(threshold_reg) + $urandom_range(0, 3) - 1;
      other = $urandom_range(0, 1) ? level + delta : level - delta;
      if (other < 0) other = 0;
      if (other > 255) other = 255;
      p = gray_pair(level, other, last);
    end else begin
      p.ref_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.cur_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.cur_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.cur_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.frame_end = last;
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_pair_t p);
    int gap;
    pix       <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    account_pixel(p);
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pixels that end no frame leave nothing in the queue, so the pipeline
  // is given a settling time after the last result.
  task automatic wait_until_idle();
    pix_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:    width_reg     = value[FRAME_WIDTH_W-1:0];
      REG_SAMPLE_STRIDE:  stride_reg    = value[STRIDE_W-1:0];
      REG_DIFF_THRESHOLD: threshold_reg = value[THRESH_W-1:0];
      REG_COUNT_LIMIT:    limit_reg     = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int width, input int stride, input int threshold,
                           input int limit, input logic [3:0] which);
    wait_until_idle();
    if (which[REG_FRAME_WIDTH])    put_register(REG_FRAME_WIDTH, CFG_DATA_W'(width));
    if (which[REG_SAMPLE_STRIDE])  put_register(REG_SAMPLE_STRIDE, CFG_DATA_W'(stride));
    if (which[REG_DIFF_THRESHOLD]) put_register(REG_DIFF_THRESHOLD, CFG_DATA_W'(threshold));
    if (which[REG_COUNT_LIMIT])    put_register(REG_COUNT_LIMIT, CFG_DATA_W'(limit));
    cfg_write <= 1'b0;
  endtask

  task automatic test_default_registers();
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(255, 0, 1'b1));
    send_pixel(gray_pair(255, 0, 1'b1));
  endtask

  task automatic test_threshold();
    configure(1, 1, 30, 1000, 4'hF);
    send_pixel(gray_pair(100, 130, 1'b0));
    send_pixel(gray_pair(100, 131, 1'b0));
    send_pixel(gray_pair(131, 100, 1'b1));
    configure(0, 0, 0, 0, 4'b0100);
    send_pixel(gray_pair(77, 77, 1'b0));
    send_pixel(gray_pair(77, 78, 1'b1));
    configure(0, 0, 255, 0, 4'b0100);
    send_pixel(gray_pair(0, 255, 1'b1));
  endtask

  // With a limit of zero the first change latches the flag and later
  // changes are no longer counted.
  task automatic test_count_limit();
    configure(0, 0, 30, 0, 4'b1100);
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(255, 0, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b1));
  endtask

  task automatic test_register_clamps();
    configure(0, 0, 0, 1000, 4'b1011);
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b1));
    configure(8191, 31, 0, 20'hFFFFF, 4'b1011);
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b1));
  endtask

  task automatic test_change_within_frame();
    configure(4, 2, 30, 1000, 4'hF);
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b0));
    configure(0, 1, 0, 0, 4'b0010);
    send_pixel(gray_pair(0, 255, 1'b0));
    send_pixel(gray_pair(0, 255, 1'b1));
  endtask

  task automatic test_random_frames();
    int frames;
    int sent;
    int len;
    int roll;
    int width;
    int stride;
    int threshold;
    int limit;
    frames = 0;
    sent   = 0;
    while (sent < RANDOM_ITEMS || frames < MIN_FRAMES) begin
      if (frames % 4 == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) width = $urandom_range(1, 8);
        else if (roll < 80) width = $urandom_range(9, 40);
        else if (roll < 90) width = 0;
        else width = $urandom_range(4096, 8191);
        roll = $urandom_range(0, 99);
        if (roll < 70) stride = $urandom_range(1, 4);
        else if (roll < 85) stride = 0;
        else stride = $urandom_range(5, 31);
        roll = $urandom_range(0, 99);
        if (roll < 60) threshold = $urandom_range(0, 40);
        else if (roll < 90) threshold = $urandom_range(41, 254);
        else threshold = $urandom_range(0, 1) ? 255 : 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) limit = $urandom_range(0, 8);
        else if (roll < 90) limit = $urandom_range(9, 100);
        else if (roll < 97) limit = $urandom_range(0, 20'hFFFFF);
        else limit = 20'hFFFFF;
        configure(width, stride, threshold, limit,
                  (frames == 0) ? 4'hF : 4'($urandom_range(1, 15)));
      end
      gaps_enabled = ($urandom_range(0, 4) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 65) len = $urandom_range(1, 12);
      else if (roll < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 150);
      for (int k = 0; k < len; k++) send_pixel(random_pixel(k == len - 1));
      sent += len;
      frames++;
    end
    gaps_enabled = 1'b1;
  endtask

  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall = ready_stall - 1;
      res_ready <= 1'b0;
    end else if (!gaps_enabled || $urandom_range(0, 99) < 70) begin
      res_ready <= 1'b1;
    end else begin
      ready_stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      res_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no frame pending: change_detected=%0b changed_count=%0d",
               res.change_detected, res.changed_count);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (res.change_detected !== oldest_result.change_detected) begin
          $error("change_detected: expected %0b, got %0b",
                 oldest_result.change_detected, res.change_detected);
          mismatch_count++;
        end
        if (res.changed_count !== oldest_result.changed_count) begin
          $error("changed_count: expected %0d, got %0d",
                 oldest_result.changed_count, res.changed_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    width_reg     = FRAME_WIDTH_RESET;
    stride_reg    = SAMPLE_STRIDE_RESET;
    threshold_reg = DIFF_THRESHOLD_RESET;
    limit_reg     = COUNT_LIMIT_RESET;
    clear_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_threshold();
    test_count_limit();
    test_register_clamps();
    test_change_within_frame();
    test_random_frames();
    wait_until_idle();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
